// ===== hdl/psae_pkg.sv =====
// ----------------------------------------------------------------------------
// psae_pkg
// Shared types and constants for the program stream audio extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package psae_pkg;

   localparam logic [31:0] CODE_PACK       = 32'h0000_01BA;
   localparam logic [31:0] CODE_END        = 32'h0000_01B9;
   localparam logic [23:0] CODE_PREFIX     = 24'h00_0001;
   localparam logic [1:0]  PES_FIXED_BYTES = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_AUDIO_STREAM_ID  = 2'd0;
   localparam logic [1:0] CSR_EXTRA_SKIP       = 2'd1;
   localparam logic [1:0] CSR_PACK_BODY_LENGTH = 2'd2;

   localparam logic [7:0] AUDIO_STREAM_ID_RESET  = 8'hBD;
   localparam logic [3:0] EXTRA_SKIP_RESET       = 4'd4;
   localparam logic [7:0] PACK_BODY_LENGTH_RESET = 8'd10;

   // status codes
   localparam logic [1:0] STATUS_PARSING   = 2'd0;
   localparam logic [1:0] STATUS_END       = 2'd1;
   localparam logic [1:0] STATUS_NOT_PS    = 2'd2;
   localparam logic [1:0] STATUS_MALFORMED = 2'd3;

   typedef struct packed {
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic       packet_last;
      logic [1:0] status;
   } result_type;

endpackage

`default_nettype wire

// ===== hdl/psae_parser.sv =====
// ----------------------------------------------------------------------------
// psae_parser
// Packet walker: holds the parse state and works out the result word for the
// byte presented on step, updating its state at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module psae_parser (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire logic [7:0]           stream_byte,
   input  wire logic [7:0]           audio_stream_id,
   input  wire logic [3:0]           extra_skip,
   input  wire logic [7:0]           pack_body_length,
   output      psae_pkg::result_type result
);
   import psae_pkg::*;

   localparam logic [2:0] PH_CODE    = 3'd0;
   localparam logic [2:0] PH_LEN     = 3'd1;
   localparam logic [2:0] PH_SKIP    = 3'd2;
   localparam logic [2:0] PH_PESHDR  = 3'd3;
   localparam logic [2:0] PH_HSKIP   = 3'd4;
   localparam logic [2:0] PH_PAYLOAD = 3'd5;
   localparam logic [2:0] PH_HALT    = 3'd6;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] code_ff, code_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] remaining_ff, remaining_in;
   logic        first_ff, first_in;
   logic [1:0]  status_ff, status_in;
   logic        audio_ff, audio_in;

   logic [15:0] count_inc;
   logic [15:0] count_dec;
   logic [15:0] remaining_dec;
   logic [16:0] need;
   logic [8:0]  hdr_skip;
   logic [16:0] leftover;

   assign count_inc     = count_ff + 16'd1;
   assign count_dec     = count_ff - 16'd1;
   assign remaining_dec = remaining_ff - 16'd1;
   assign hdr_skip      = {1'b0, stream_byte} + {5'd0, extra_skip};
   assign need          = {15'd0, PES_FIXED_BYTES} + {8'd0, hdr_skip};
   assign leftover      = {1'b0, length_ff} - need;

   always_comb begin
      phase_in     = phase_ff;
      code_in      = code_ff;
      count_in     = count_ff;
      length_in    = length_ff;
      remaining_in = remaining_ff;
      first_in     = first_ff;
      status_in    = status_ff;
      audio_in     = audio_ff;
      result       = '0;

      case (phase_ff)
         PH_CODE: begin
            code_in  = {code_ff[23:0], stream_byte};
            count_in = count_inc;
            if (count_inc >= 16'd4) begin
               count_in = '0;
               first_in = 1'b0;
               if (first_ff && code_in != CODE_PACK) begin
                  status_in = STATUS_NOT_PS;
                  phase_in  = PH_HALT;
               end else if (code_in == CODE_PACK) begin
                  count_in = {8'd0, pack_body_length};
                  phase_in = (pack_body_length != 8'd0) ? PH_SKIP : PH_CODE;
               end else if (code_in == CODE_END) begin
                  status_in = STATUS_END;
                  phase_in  = PH_HALT;
               end else begin
                  audio_in  = (code_in == {CODE_PREFIX, audio_stream_id});
                  length_in = '0;
                  phase_in  = PH_LEN;
               end
            end
         end
         PH_LEN: begin
            length_in = {length_ff[7:0], stream_byte};
            count_in  = count_inc;
            if (count_inc >= 16'd2) begin
               if (audio_ff) begin
                  count_in = '0;
                  phase_in = PH_PESHDR;
               end else begin
                  count_in = length_in;
                  phase_in = (length_in != 16'd0) ? PH_SKIP : PH_CODE;
               end
            end
         end
         PH_SKIP: begin
            count_in = count_dec;
            if (count_dec == 16'd0) begin
               phase_in = PH_CODE;
            end
         end
         PH_PESHDR: begin
            count_in = count_inc;
            // third header byte carries the header-data length
            if (count_inc >= {14'd0, PES_FIXED_BYTES}) begin
               if ({1'b0, length_ff} < need) begin
                  status_in = STATUS_MALFORMED;
                  phase_in  = PH_HALT;
               end else begin
                  remaining_in = leftover[15:0];
                  if (hdr_skip != 9'd0) begin
                     count_in = {7'd0, hdr_skip};
                     phase_in = PH_HSKIP;
                  end else begin
                     count_in = '0;
                     phase_in = (leftover[15:0] != 16'd0) ? PH_PAYLOAD : PH_CODE;
                  end
               end
            end
         end
         PH_HSKIP: begin
            count_in = count_dec;
            if (count_dec == 16'd0) begin
               phase_in = (remaining_ff != 16'd0) ? PH_PAYLOAD : PH_CODE;
            end
         end
         PH_PAYLOAD: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = stream_byte;
            remaining_in         = remaining_dec;
            if (remaining_dec == 16'd0) begin
               result.packet_last = 1'b1;
               phase_in           = PH_CODE;
               count_in           = '0;
            end
         end
         PH_HALT: begin
         end
         default: begin
            phase_in = PH_HALT;
         end
      endcase

      result.status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_CODE;
         code_ff      <= '0;
         count_ff     <= '0;
         length_ff    <= '0;
         remaining_ff <= '0;
         first_ff     <= 1'b1;
         status_ff    <= STATUS_PARSING;
         audio_ff     <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         code_ff      <= code_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         remaining_ff <= remaining_in;
         first_ff     <= first_in;
         status_ff    <= status_in;
         audio_ff     <= audio_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/program_stream_audio_extractor.sv =====
// An accepted byte's result word is in the output register in the cycle after it is taken.
// The block takes one byte per clock while req_stall is low; the parse state updates once per accepted byte.
// The output register is refilled in the cycle it is drained, so a stall only
// holds the input while the held word is not taken.
// Reset (synchronous) returns the parser to waiting for a pack code and restores
// the register defaults; the block accepts input right after reset.
// ----------------------------------------------------------------------------
// program_stream_audio_extractor
// Walks an MPEG program stream a byte at a time and passes the payload bytes
// of packets carrying the configured stream id, with a parse status on every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module program_stream_audio_extractor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_stream_byte,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic       rsp_payload_valid,
   output      logic [7:0] rsp_payload_byte,
   output      logic       rsp_packet_last,
   output      logic [1:0] rsp_status,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_write_data
);
   import psae_pkg::*;

   logic [7:0] audio_stream_id_ff;
   logic [3:0] extra_skip_ff;
   logic [7:0] pack_body_length_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_word_ff;
   result_type step_result;
   logic       req_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_stream_id_ff  <= AUDIO_STREAM_ID_RESET;
         extra_skip_ff       <= EXTRA_SKIP_RESET;
         pack_body_length_ff <= PACK_BODY_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_AUDIO_STREAM_ID:  audio_stream_id_ff  <= csr_write_data;
            CSR_EXTRA_SKIP:       extra_skip_ff       <= csr_write_data[3:0];
            CSR_PACK_BODY_LENGTH: pack_body_length_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   psae_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .step             (req_take),
      .stream_byte      (req_stream_byte),
      .audio_stream_id  (audio_stream_id_ff),
      .extra_skip       (extra_skip_ff),
      .pack_body_length (pack_body_length_ff),
      .result           (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_word_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_payload_valid = rsp_word_ff.payload_valid;
   assign rsp_payload_byte  = rsp_word_ff.payload_byte;
   assign rsp_packet_last   = rsp_word_ff.packet_last;
   assign rsp_status        = rsp_word_ff.status;

endmodule

`default_nettype wire
